// File: hdl/wsdf_pkg.sv
// shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int MAX_PAYLOAD_W = 16;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 16'd2048;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_WRAP  = 3'd0;
    localparam logic [2:0] MASK_BYTES  = 3'd4;

    typedef enum logic [6:0] {
        PH_OPCODE  = 7'b000_0001,
        PH_LEN     = 7'b000_0010,
        PH_EXT16   = 7'b000_0100,
        PH_EXT64   = 7'b000_1000,
        PH_MASK    = 7'b001_0000,
        PH_PAYLOAD = 7'b010_0000,
        PH_CLOSED  = 7'b100_0000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_EMPTY    = 3'd1,
        KIND_PONG     = 3'd2,
        KIND_CLOSE    = 3'd3,
        KIND_OVERSIZE = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       is_binary;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/websocket_frame_deframer.sv
// websocket receive-side frame deframer: header parse, unmask and result buffering
// a result goes into the output register, or into the skid stage if the output stalls, when its request is accepted
// throughput: one request per cycle; in_ready drops only while the skid stage holds a result
// a stalled output keeps one result in the output register and one in the skid stage
// reset: parser expects an opcode byte, other parser state zero, max_payload 2048
// no clearing pass; a new-connection request clears parser state when it is accepted
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer #(
    parameter int LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic             is_binary,
    output logic             last
);

    localparam int LW = LENGTH_WIDTH;
    localparam int CW = (LW > wsdf_pkg::MAX_PAYLOAD_W) ? LW : wsdf_pkg::MAX_PAYLOAD_W;

    logic [15:0]       max_payload_reg;

    wsdf_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic              mask_present_reg, mask_present_next;
    logic [2:0]        byte_counter_reg, byte_counter_next;
    logic [LW-1:0]     payload_length_reg, payload_length_next;
    logic              length_overflow_reg, length_overflow_next;
    logic [31:0]       mask_key_reg, mask_key_next;
    logic [LW-1:0]     payload_index_reg, payload_index_next;

    wsdf_pkg::res_t    res_next;
    logic              res_valid;
    wsdf_pkg::res_t    out_reg;
    logic              out_valid_reg;
    wsdf_pkg::res_t    skid_reg;
    logic              skid_valid_reg;

    logic              in_fire;
    logic              out_fire;
    logic              len_done;
    logic              fin_req;
    logic              fin_had_payload;
    logic [LW+7:0]     ext_cat;
    logic [LW:0]       index_inc;
    logic              is_last;
    logic              is_msg;
    logic [7:0]        key_byte;
    logic [CW-1:0]     cmp_len;
    logic [CW-1:0]     cmp_max;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign data_byte = out_reg.data;
    assign is_binary = out_reg.is_binary;
    assign last      = out_reg.last;

    assign is_msg    = (opcode_reg == wsdf_pkg::OP_TEXT) || (opcode_reg == wsdf_pkg::OP_BINARY);
    assign ext_cat   = {payload_length_reg, rx_byte};
    assign index_inc = {1'b0, payload_index_reg} + {{LW{1'b0}}, 1'b1};
    assign is_last   = index_inc >= {1'b0, payload_length_reg};

    always_comb
    begin
        case (payload_index_reg[1:0])
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // parser step for one request
    always_comb
    begin
        phase_next           = phase_reg;
        opcode_next          = opcode_reg;
        mask_present_next    = mask_present_reg;
        byte_counter_next    = byte_counter_reg;
        payload_length_next  = payload_length_reg;
        length_overflow_next = length_overflow_reg;
        mask_key_next        = mask_key_reg;
        payload_index_next   = payload_index_reg;
        res_valid            = 1'b0;
        res_next.kind        = wsdf_pkg::KIND_DATA;
        res_next.data        = 8'd0;
        res_next.is_binary   = 1'b0;
        res_next.last        = 1'b0;
        len_done             = 1'b0;
        fin_req              = 1'b0;
        fin_had_payload      = 1'b0;
        cmp_len              = '0;
        cmp_max              = '0;

        if (cmd)
        begin
            phase_next           = wsdf_pkg::PH_OPCODE;
            opcode_next          = 4'd0;
            mask_present_next    = 1'b0;
            byte_counter_next    = 3'd0;
            payload_length_next  = '0;
            length_overflow_next = 1'b0;
            mask_key_next        = 32'd0;
            payload_index_next   = '0;
        end
        else
        begin
            case (phase_reg)
                wsdf_pkg::PH_OPCODE:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = wsdf_pkg::PH_LEN;
                end
                wsdf_pkg::PH_LEN:
                begin
                    mask_present_next    = rx_byte[7];
                    payload_length_next  = '0;
                    length_overflow_next = 1'b0;
                    byte_counter_next    = 3'd0;
                    if (rx_byte[6:0] == wsdf_pkg::LEN_EXT16)
                    begin
                        phase_next = wsdf_pkg::PH_EXT16;
                    end
                    else if (rx_byte[6:0] == wsdf_pkg::LEN_EXT64)
                    begin
                        phase_next = wsdf_pkg::PH_EXT64;
                    end
                    else
                    begin
                        payload_length_next = LW'(rx_byte[6:0]);
                        len_done            = 1'b1;
                    end
                end
                wsdf_pkg::PH_EXT16, wsdf_pkg::PH_EXT64:
                begin
                    if (|payload_length_reg[LW-1:LW-8])
                    begin
                        length_overflow_next = 1'b1;
                    end
                    payload_length_next = ext_cat[LW-1:0];
                    byte_counter_next   = byte_counter_reg + 3'd1;
                    if (phase_reg == wsdf_pkg::PH_EXT16)
                    begin
                        len_done = (byte_counter_next == wsdf_pkg::EXT16_BYTES);
                    end
                    else
                    begin
                        len_done = (byte_counter_next == wsdf_pkg::EXT64_WRAP);
                    end
                end
                wsdf_pkg::PH_MASK:
                begin
                    mask_key_next     = {mask_key_reg[23:0], rx_byte};
                    byte_counter_next = byte_counter_reg + 3'd1;
                    if (byte_counter_next == wsdf_pkg::MASK_BYTES)
                    begin
                        byte_counter_next = 3'd0;
                        if (payload_length_reg == '0)
                        begin
                            fin_req = 1'b1;
                        end
                        else
                        begin
                            phase_next = wsdf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsdf_pkg::PH_PAYLOAD:
                begin
                    payload_index_next = index_inc[LW-1:0];
                    if (is_msg)
                    begin
                        res_valid          = 1'b1;
                        res_next.data      = mask_present_reg ? (rx_byte ^ key_byte) : rx_byte;
                        res_next.is_binary = (opcode_reg == wsdf_pkg::OP_BINARY);
                        res_next.last      = is_last;
                        if (is_last)
                        begin
                            phase_next = wsdf_pkg::PH_OPCODE;
                        end
                    end
                    else if (is_last)
                    begin
                        fin_req         = 1'b1;
                        fin_had_payload = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = wsdf_pkg::PH_CLOSED;
                end
            endcase

            // length known: size check (oversize closes), then mask, payload or frame end
            if (len_done)
            begin
                cmp_len = CW'(payload_length_next);
                cmp_max = CW'(max_payload_reg);
                if (length_overflow_next || (cmp_len > cmp_max))
                begin
                    phase_next    = wsdf_pkg::PH_CLOSED;
                    res_valid     = 1'b1;
                    res_next.kind = wsdf_pkg::KIND_OVERSIZE;
                end
                else
                begin
                    byte_counter_next  = 3'd0;
                    payload_index_next = '0;
                    if (mask_present_next)
                    begin
                        mask_key_next = 32'd0;
                        phase_next    = wsdf_pkg::PH_MASK;
                    end
                    else if (payload_length_next == '0)
                    begin
                        fin_req = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end

            // frame complete: act on the opcode
            if (fin_req)
            begin
                phase_next = wsdf_pkg::PH_OPCODE;
                if (opcode_reg == wsdf_pkg::OP_CLOSE)
                begin
                    phase_next    = wsdf_pkg::PH_CLOSED;
                    res_valid     = 1'b1;
                    res_next.kind = wsdf_pkg::KIND_CLOSE;
                end
                else if (opcode_reg == wsdf_pkg::OP_PING)
                begin
                    res_valid     = 1'b1;
                    res_next.kind = wsdf_pkg::KIND_PONG;
                end
                else if (is_msg && !fin_had_payload)
                begin
                    res_valid          = 1'b1;
                    res_next.kind      = wsdf_pkg::KIND_EMPTY;
                    res_next.is_binary = (opcode_reg == wsdf_pkg::OP_BINARY);
                    res_next.last      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= wsdf_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_payload_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= wsdf_pkg::PH_OPCODE;
            opcode_reg          <= 4'd0;
            mask_present_reg    <= 1'b0;
            byte_counter_reg    <= 3'd0;
            payload_length_reg  <= '0;
            length_overflow_reg <= 1'b0;
            mask_key_reg        <= 32'd0;
            payload_index_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg           <= phase_next;
            opcode_reg          <= opcode_next;
            mask_present_reg    <= mask_present_next;
            byte_counter_reg    <= byte_counter_next;
            payload_length_reg  <= payload_length_next;
            length_overflow_reg <= length_overflow_next;
            mask_key_reg        <= mask_key_next;
            payload_index_reg   <= payload_index_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsdf_pkg::PH_CLOSED && in_fire && !cmd) |=>
            (phase_reg == wsdf_pkg::PH_CLOSED))
        else $error("closed connection reopened without a new-connection request");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd) |=> (phase_reg == wsdf_pkg::PH_OPCODE && payload_index_reg == '0))
        else $error("new-connection request did not clear the parser");

    a_control_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == wsdf_pkg::KIND_PONG
            || out_reg.kind == wsdf_pkg::KIND_CLOSE
            || out_reg.kind == wsdf_pkg::KIND_OVERSIZE))
        |-> (out_reg.data == 8'd0 && !out_reg.is_binary && !out_reg.last))
        else $error("control result carries payload fields");

endmodule

`default_nettype wire
